// ===== rtl/core/quad_x_motor_mixer_arming_defines.svh =====
// assertion macros for the quad-x motor mixer
`ifndef QUAD_X_MOTOR_MIXER_ARMING_DEFINES_SVH
`define QUAD_X_MOTOR_MIXER_ARMING_DEFINES_SVH

`ifndef SYNTHESIS
`define QXM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QXM_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QXM_ASSERT_RST(lbl, prop, msg)
`define QXM_ASSERT_CLK(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/qxm_pkg.sv =====
// types and constants shared by the quad-x motor mixer
`default_nettype none
package qxm_pkg;

  localparam logic [2:0] REG_THR_MIN   = 3'd0;
  localparam logic [2:0] REG_THR_DZ    = 3'd1;
  localparam logic [2:0] REG_YAW_MIN   = 3'd2;
  localparam logic [2:0] REG_YAW_DZ    = 3'd3;
  localparam logic [2:0] REG_MIN_SIG   = 3'd4;
  localparam logic [2:0] REG_MAX_SIG   = 3'd5;
  localparam logic [2:0] REG_BND_EN    = 3'd6;
  localparam logic [2:0] REG_HOLD_MS   = 3'd7;

  localparam logic [11:0] RST_RADIO_MIN = 12'd1000;
  localparam logic [9:0]  RST_DEAD_ZONE = 10'd20;
  localparam logic [11:0] RST_MIN_SIG   = 12'd1000;
  localparam logic [11:0] RST_MAX_SIG   = 12'd2000;
  localparam logic [15:0] RST_HOLD_MS   = 16'd1000;
  localparam logic [11:0] STICK_FLOOR   = 12'd100;

  typedef struct packed {
    logic signed [15:0] fl;
    logic signed [15:0] fr;
    logic signed [15:0] bl;
    logic signed [15:0] br;
  } mix_t;

  typedef struct packed {
    logic        en;
    logic [11:0] min_sig;
    logic [11:0] max_sig;
  } bnd_cfg_t;

  typedef struct packed {
    logic armed;
    logic toggled;
  } arm_flags_t;

endpackage
`default_nettype wire

// ===== rtl/core/qxm_mix.sv =====
// quad-x mix of throttle and corrections, rounded to whole microseconds
`default_nettype none
module qxm_mix
  import qxm_pkg::*;
(
  input  wire logic [15:0]        throttle_cmd,
  input  wire logic signed [15:0] pitch_corr,
  input  wire logic signed [15:0] roll_corr,
  input  wire logic signed [15:0] yaw_corr,
  output mix_t                    mix
);

  function automatic logic signed [15:0] rnd_q4(input logic signed [19:0] s);
    logic [19:0] mag;
    logic [19:0] q;
    mag = s[19] ? 20'(-s) : 20'(s);
    q   = (mag + 20'd8) >> 4;
    return s[19] ? -$signed(q[15:0]) : $signed(q[15:0]);
  endfunction

  logic signed [19:0] t, p, r, y;

  always_comb begin
    t = $signed({4'b0, throttle_cmd});
    p = 20'(pitch_corr);
    r = 20'(roll_corr);
    y = 20'(yaw_corr);
    mix.fl = rnd_q4(t + p - r + y);
    mix.fr = rnd_q4(t + p + r - y);
    mix.bl = rnd_q4(t - p - r - y);
    mix.br = rnd_q4(t - p + r + y);
  end

endmodule
`default_nettype wire

// ===== rtl/core/qxm_shape.sv =====
// bounds shift and timer compare scaling with saturation
`default_nettype none
module qxm_shape
  import qxm_pkg::*;
(
  input  wire mix_t        mix,
  input  wire bnd_cfg_t    cfg,
  input  wire logic        armed,
  output logic      [15:0] fl_cmp,
  output logic      [15:0] fr_cmp,
  output logic      [15:0] bl_cmp,
  output logic      [15:0] br_cmp
);

  function automatic logic [15:0] to_cmp(input logic signed [17:0] v);
    logic signed [19:0] c;
    c = 20'(v) * 20'sd3;
    if (c < 0) return 16'd0;
    else if (c > 20'sd65535) return 16'hffff;
    else return c[15:0];
  endfunction

  logic signed [15:0] lo, hi, lo_a, lo_b, hi_a, hi_b, min_s, max_s;
  logic signed [16:0] fix;

  always_comb begin
    lo_a  = (mix.fl < mix.fr) ? mix.fl : mix.fr;
    lo_b  = (mix.bl < mix.br) ? mix.bl : mix.br;
    hi_a  = (mix.fl > mix.fr) ? mix.fl : mix.fr;
    hi_b  = (mix.bl > mix.br) ? mix.bl : mix.br;
    lo    = (lo_a < lo_b) ? lo_a : lo_b;
    hi    = (hi_a > hi_b) ? hi_a : hi_b;
    min_s = $signed({4'b0, cfg.min_sig});
    max_s = $signed({4'b0, cfg.max_sig});
    fix   = '0;
    if (cfg.en) begin
      if (lo < min_s) fix = 17'(min_s) - 17'(lo);
      else if (hi > max_s) fix = 17'(max_s) - 17'(hi);
    end
    fl_cmp = armed ? to_cmp(18'(mix.fl) + 18'(fix)) : 16'd0;
    fr_cmp = armed ? to_cmp(18'(mix.fr) + 18'(fix)) : 16'd0;
    bl_cmp = armed ? to_cmp(18'(mix.bl) + 18'(fix)) : 16'd0;
    br_cmp = armed ? to_cmp(18'(mix.br) + 18'(fix)) : 16'd0;
  end

endmodule
`default_nettype wire

// ===== rtl/core/quad_x_motor_mixer_arming.sv =====
// quad-x motor mixer with stick arming, top level
// an accepted input beat is held in the input register stage, then in the result register stage
// throughput: one beat per cycle while in_tready stays high; arming state updates as each beat is accepted
// two register stages; in_tready drops only while both hold a beat and out_tready is low
// reset (rst_n low, synchronous): disarmed, no pending arm, registers at defaults
`default_nettype none
`include "quad_x_motor_mixer_arming_defines.svh"
module quad_x_motor_mixer_arming
  import qxm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [15:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // throttle_cmd, pitch_corr, roll_corr, yaw_corr, throttle_pulse_in,
  // yaw_pulse_in, now_ms
  input  wire logic [119:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // front_left_compare, front_right_compare, back_left_compare,
  // back_right_compare, armed_now, arm_toggled, zero pad
  output logic [71:0]       out_tdata,
  // drive_valid
  output logic              out_tuser
);

  logic [11:0] thr_min_r, yaw_min_r, min_sig_r, max_sig_r;
  logic [9:0]  thr_dz_r, yaw_dz_r;
  logic        bnd_en_r;
  logic [15:0] hold_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_min_r <= RST_RADIO_MIN;
      thr_dz_r  <= RST_DEAD_ZONE;
      yaw_min_r <= RST_RADIO_MIN;
      yaw_dz_r  <= RST_DEAD_ZONE;
      min_sig_r <= RST_MIN_SIG;
      max_sig_r <= RST_MAX_SIG;
      bnd_en_r  <= 1'b0;
      hold_ms_r <= RST_HOLD_MS;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THR_MIN: thr_min_r <= cfg_wdata[11:0];
        REG_THR_DZ:  thr_dz_r  <= cfg_wdata[9:0];
        REG_YAW_MIN: yaw_min_r <= cfg_wdata[11:0];
        REG_YAW_DZ:  yaw_dz_r  <= cfg_wdata[9:0];
        REG_MIN_SIG: min_sig_r <= cfg_wdata[11:0];
        REG_MAX_SIG: max_sig_r <= cfg_wdata[11:0];
        REG_BND_EN:  bnd_en_r  <= cfg_wdata[0];
        REG_HOLD_MS: hold_ms_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input fields
  logic [11:0] thr_pulse, yaw_pulse;
  logic [31:0] now_ms;
  assign thr_pulse = in_tdata[75:64];
  assign yaw_pulse = in_tdata[87:76];
  assign now_ms    = in_tdata[119:88];

  logic in_acc, s1_adv, out_free;
  logic s1_valid_r, out_valid_r;
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // arming
  logic        armed_r, pending_r, armed_nxt, pending_nxt;
  logic [31:0] start_ms_r, start_ms_nxt;
  logic        stick_ok, pend_mid, toggle;
  logic [12:0] thr_lim, yaw_lim;

  always_comb begin
    thr_lim  = {1'b0, thr_min_r} + {3'b0, thr_dz_r};
    yaw_lim  = {1'b0, yaw_min_r} + {3'b0, yaw_dz_r};
    stick_ok = ({1'b0, thr_pulse} < thr_lim) && ({1'b0, yaw_pulse} < yaw_lim) &&
               (thr_pulse > STICK_FLOOR) && (yaw_pulse > STICK_FLOOR);
    pend_mid     = stick_ok;
    start_ms_nxt = (stick_ok && !pending_r) ? now_ms : start_ms_r;
    toggle       = pend_mid && ((now_ms - start_ms_nxt) > {16'b0, hold_ms_r});
    armed_nxt    = armed_r ^ toggle;
    pending_nxt  = pend_mid && !toggle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      pending_r  <= 1'b0;
      start_ms_r <= '0;
    end else if (in_acc) begin
      armed_r    <= armed_nxt;
      pending_r  <= pending_nxt;
      start_ms_r <= start_ms_nxt;
    end
  end

  // input register stage
  mix_t       mix, s1_mix_r;
  arm_flags_t s1_flags_r;

  qxm_mix u_mix (
    .throttle_cmd (in_tdata[15:0]),
    .pitch_corr   ($signed(in_tdata[31:16])),
    .roll_corr    ($signed(in_tdata[47:32])),
    .yaw_corr     ($signed(in_tdata[63:48])),
    .mix          (mix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (in_tready) s1_valid_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mix_r           <= mix;
      s1_flags_r.armed   <= armed_nxt;
      s1_flags_r.toggled <= toggle;
    end
  end

  // result register stage
  bnd_cfg_t    bnd_cfg;
  logic [15:0] fl_cmp, fr_cmp, bl_cmp, br_cmp;
  logic [71:0] out_data_r;
  logic        out_user_r;

  assign bnd_cfg = '{en: bnd_en_r, min_sig: min_sig_r, max_sig: max_sig_r};

  qxm_shape u_shape (
    .mix    (s1_mix_r),
    .cfg    (bnd_cfg),
    .armed  (s1_flags_r.armed),
    .fl_cmp (fl_cmp),
    .fr_cmp (fr_cmp),
    .bl_cmp (bl_cmp),
    .br_cmp (br_cmp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_free) out_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {6'b0, s1_flags_r.toggled, s1_flags_r.armed,
                     br_cmp, bl_cmp, fr_cmp, fl_cmp};
      out_user_r <= s1_flags_r.armed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `QXM_ASSERT_RST(a_disarmed_zero, out_tvalid && !out_tuser |-> out_tdata[63:0] == 64'd0, "disarmed beat carries nonzero compare")
  `QXM_ASSERT_RST(a_drive_matches_armed, out_tvalid |-> out_tuser == out_tdata[64], "drive_valid differs from armed_now")
  `QXM_ASSERT_RST(a_arm_only_on_beat, !(in_tvalid && in_tready) |=> $stable(armed_r), "armed changed without an input beat")
  `QXM_ASSERT_RST(a_ready_when_empty, !out_tvalid |-> in_tready, "input stalled with empty output")
  `QXM_ASSERT_RST(a_toggle_clears_pending, in_acc && toggle |=> !pending_r, "arm pending survived a toggle")

endmodule
`default_nettype wire

// ===== dv/qxm_mixer_checker.sv =====
`timescale 1ns / 1ps
// checker for the quad-x mixer: predicts every result beat and compares it with the output
module qxm_mixer_checker
  import qxm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [119:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [71:0]  out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [15:0] fl;
    logic [15:0] fr;
    logic [15:0] bl;
    logic [15:0] br;
    logic        drive_valid;
    logic        armed_now;
    logic        toggled;
  } motor_cmd_t;

  logic [11:0] thr_min;
  logic [9:0]  thr_dz;
  logic [11:0] yaw_min;
  logic [9:0]  yaw_dz;
  logic [11:0] sig_min;
  logic [11:0] sig_max;
  logic        bnd_en;
  logic [15:0] hold_ms;

  logic        armed_st;
  logic        hold_pending;
  logic [31:0] hold_start;

  motor_cmd_t  due_cmds[$];
  int          mismatches = 0;

  function automatic int round_us(input int s);
    if (s >= 0) return (s + 8) >>> 4;
    return -((-s + 8) >>> 4);
  endfunction

  function automatic logic [15:0] compare_of(input int v);
    int c;
    c = v * 3;
    if (c < 0) return 16'd0;
    if (c > 65535) return 16'hFFFF;
    return c[15:0];
  endfunction

  function automatic motor_cmd_t mix_and_arm(input logic [119:0] d);
    int          t, p, r, y;
    int          m[4];
    int          lo, hi, shift, smin, smax;
    logic [11:0] tp, yp;
    logic [31:0] now, held;
    logic        stick_low, toggled;
    motor_cmd_t  res;
    t   = {16'd0, d[15:0]};
    p   = $signed(d[31:16]);
    r   = $signed(d[47:32]);
    y   = $signed(d[63:48]);
    tp  = d[75:64];
    yp  = d[87:76];
    now = d[119:88];

    stick_low = ({1'b0, tp} < {1'b0, thr_min} + {3'b000, thr_dz}) &&
                ({1'b0, yp} < {1'b0, yaw_min} + {3'b000, yaw_dz}) &&
                tp > STICK_FLOOR && yp > STICK_FLOOR;
    if (stick_low) begin
      if (!hold_pending) begin
        hold_pending = 1'b1;
        hold_start   = now;
      end
    end else begin
      hold_pending = 1'b0;
    end
    toggled = 1'b0;
    held = now - hold_start;
    if (hold_pending && held > {16'd0, hold_ms}) begin
      armed_st     = !armed_st;
      hold_pending = 1'b0;
      toggled      = 1'b1;
    end

    m[0] = round_us(t + p - r + y);
    m[1] = round_us(t + p + r - y);
    m[2] = round_us(t - p - r - y);
    m[3] = round_us(t - p + r + y);

    if (bnd_en) begin
      lo = m[0];
      hi = m[0];
      for (int i = 1; i < 4; i++) begin
        if (m[i] < lo) lo = m[i];
        if (m[i] > hi) hi = m[i];
      end
      smin  = sig_min;
      smax  = sig_max;
      shift = 0;
      if (lo < smin) shift = smin - lo;
      else if (hi > smax) shift = smax - hi;
      for (int i = 0; i < 4; i++) m[i] += shift;
    end

    res.fl          = armed_st ? compare_of(m[0]) : 16'd0;
    res.fr          = armed_st ? compare_of(m[1]) : 16'd0;
    res.bl          = armed_st ? compare_of(m[2]) : 16'd0;
    res.br          = armed_st ? compare_of(m[3]) : 16'd0;
    res.drive_valid = armed_st;
    res.armed_now   = armed_st;
    res.toggled     = toggled;
    return res;
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    motor_cmd_t want;
    if (!rst_n) begin
      thr_min      = RST_RADIO_MIN;
      thr_dz       = RST_DEAD_ZONE;
      yaw_min      = RST_RADIO_MIN;
      yaw_dz       = RST_DEAD_ZONE;
      sig_min      = RST_MIN_SIG;
      sig_max      = RST_MAX_SIG;
      bnd_en       = 1'b0;
      hold_ms      = RST_HOLD_MS;
      armed_st     = 1'b0;
      hold_pending = 1'b0;
      hold_start   = '0;
      due_cmds.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_cmds.size() == 0) begin
          $error("result beat with nothing pending");
          mismatches++;
        end else begin
          want = due_cmds.pop_front();
          check_field("front_left_compare", want.fl, out_tdata[15:0]);
          check_field("front_right_compare", want.fr, out_tdata[31:16]);
          check_field("back_left_compare", want.bl, out_tdata[47:32]);
          check_field("back_right_compare", want.br, out_tdata[63:48]);
          check_field("armed_now", want.armed_now, out_tdata[64]);
          check_field("arm_toggled", want.toggled, out_tdata[65]);
          check_field("drive_valid", want.drive_valid, out_tuser);
        end
      end
      if (in_tvalid && in_tready) due_cmds.push_back(mix_and_arm(in_tdata));
      if (cfg_we) begin
        case (cfg_addr)
          REG_THR_MIN: thr_min = cfg_wdata[11:0];
          REG_THR_DZ:  thr_dz  = cfg_wdata[9:0];
          REG_YAW_MIN: yaw_min = cfg_wdata[11:0];
          REG_YAW_DZ:  yaw_dz  = cfg_wdata[9:0];
          REG_MIN_SIG: sig_min = cfg_wdata[11:0];
          REG_MAX_SIG: sig_max = cfg_wdata[11:0];
          REG_BND_EN:  bnd_en  = cfg_wdata[0];
          REG_HOLD_MS: hold_ms = cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    pending    <= due_cmds.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top: drives stick and mix beats plus register writes into the mixer, gives the verdict
module tb_top;
  import qxm_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [15:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  // throttle_cmd, pitch_corr, roll_corr, yaw_corr, throttle_pulse_in, yaw_pulse_in, now_ms
  logic [119:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // fl, fr, bl, br compare, armed_now, arm_toggled, zero pad
  logic [71:0]  out_tdata;
  // drive_valid
  logic         out_tuser;

  int           fail_count;
  int           pending;
  logic         idle_on;
  logic         long_hold_req;
  int           beats_sent;
  logic [31:0]  clock_ms;

  logic [11:0]  thr_min_set;
  logic [9:0]   thr_dz_set;
  logic [11:0]  yaw_min_set;
  logic [9:0]   yaw_dz_set;
  logic [15:0]  hold_set;

  quad_x_motor_mixer_arming u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  qxm_mixer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic pause_input(input int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tdata  <= 120'({$urandom, $urandom, $urandom, $urandom});
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_beat(input logic [15:0] thr, input logic [15:0] p, input logic [15:0] r,
                           input logic [15:0] y, input logic [11:0] tp, input logic [11:0] yp,
                           input logic [31:0] now);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {now, yp, tp, y, r, p, thr};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (idle_on && $urandom_range(0, 4) == 0) pause_input($urandom_range(1, 16));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // registers change only once every result is out and the pipe has drained
  task automatic set_config(input logic [11:0] tmin, input logic [9:0] tdz,
                            input logic [11:0] ymin, input logic [9:0] ydz,
                            input logic [11:0] smin, input logic [11:0] smax,
                            input logic ben, input logic [15:0] hold);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_THR_MIN, {4'd0, tmin});
    write_reg(REG_THR_DZ, {6'd0, tdz});
    write_reg(REG_YAW_MIN, {4'd0, ymin});
    write_reg(REG_YAW_DZ, {6'd0, ydz});
    write_reg(REG_MIN_SIG, {4'd0, smin});
    write_reg(REG_MAX_SIG, {4'd0, smax});
    write_reg(REG_BND_EN, {15'd0, ben});
    write_reg(REG_HOLD_MS, hold);
    thr_min_set = tmin;
    thr_dz_set  = tdz;
    yaw_min_set = ymin;
    yaw_dz_set  = ydz;
    hold_set    = hold;
  endtask

  function automatic logic [11:0] stick_pulse(input logic low, input logic [11:0] rmin,
                                              input logic [9:0] dz);
    int lim;
    lim = rmin + dz;
    if (low && lim > 102) return 12'($urandom_range(101, (lim > 4096) ? 4095 : lim - 1));
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [15:0] small_corr();
    int v;
    v = int'($urandom_range(0, 9600)) - 4800;
    return v[15:0];
  endfunction

  task automatic flight_beat(input logic sticks_low, input logic wild);
    logic [15:0] thr, p, r, y;
    logic [11:0] tp, yp;
    logic [31:0] now;
    tp = stick_pulse(sticks_low, thr_min_set, thr_dz_set);
    yp = stick_pulse(sticks_low, yaw_min_set, yaw_dz_set);
    if ($urandom_range(0, 15) == 0) clock_ms += hold_set + $urandom_range(0, 2);
    else clock_ms += $urandom_range(0, hold_set / 3 + 3);
    if (wild) begin
      thr = 16'($urandom);
      p   = 16'($urandom);
      r   = 16'($urandom);
      y   = 16'($urandom);
      now = $urandom;
    end else begin
      thr = 16'($urandom_range(16 * 900, 16 * 2100));
      p   = small_corr();
      r   = small_corr();
      y   = small_corr();
      now = clock_ms;
    end
    send_beat(thr, p, r, y, tp, yp, now);
  endtask

  // mostly arming attempts with live mix content, some broken, some plain flight, some noise
  task automatic run_phase(input int n);
    int start, kind, len;
    start = beats_sent;
    while (beats_sent - start < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        len = $urandom_range(2, 8);
        for (int i = 0; i < len; i++)
          flight_beat(!(kind == 5 && i == len / 2), $urandom_range(0, 7) == 0);
      end else if (kind < 8) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) flight_beat(1'b0, 1'b0);
      end else begin
        flight_beat(1'b0, 1'b1);
      end
    end
  endtask

  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if (!idle_on || $urandom_range(0, 2) != 0) begin
        @(negedge clk);
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    beats_sent    = 0;
    clock_ms      = 32'd0;
    thr_min_set   = RST_RADIO_MIN;
    thr_dz_set    = RST_DEAD_ZONE;
    yaw_min_set   = RST_RADIO_MIN;
    yaw_dz_set    = RST_DEAD_ZONE;
    hold_set      = RST_HOLD_MS;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field extremes while disarmed
    send_beat(16'h0000, 16'h8000, 16'h8000, 16'h8000, 12'd0, 12'd0, 32'h0000_0000);
    send_beat(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    // arm across the timestamp wrap: exactly the hold time does not toggle, one more does
    send_beat(16'd16000, 16'd0, 16'd0, 16'd0, 12'd500, 12'd500, 32'hFFFF_FFF0);
    send_beat(16'd16000, 16'd0, 16'd0, 16'd0, 12'd500, 12'd500, 32'h0000_03D8);
    send_beat(16'd16000, 16'd0, 16'd0, 16'd0, 12'd500, 12'd500, 32'h0000_03D9);
    // armed mixes, low clamp and rounding
    send_beat(16'hFFFF, 16'd0, 16'd0, 16'd0, 12'd1500, 12'd1500, 32'd2000);
    send_beat(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 12'd1500, 12'd1500, 32'd2001);
    send_beat(16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 12'd1500, 12'd1500, 32'd2002);
    send_beat(16'd8, 16'd0, 16'd0, 16'd0, 12'd1500, 12'd1500, 32'd2003);
    send_beat(16'd7, 16'd0, 16'd0, 16'd0, 12'd1500, 12'd1500, 32'd2004);
    send_beat(16'd24, 16'd0, 16'd0, 16'd0, 12'd1500, 12'd1500, 32'd2005);
    // stick window edges
    send_beat(16'd16000, 16'd0, 16'd0, 16'd0, 12'd1019, 12'd101, 32'd3000);
    send_beat(16'd16000, 16'd0, 16'd0, 16'd0, 12'd1020, 12'd101, 32'd5000);
    send_beat(16'd16000, 16'd0, 16'd0, 16'd0, 12'd101, 12'd1019, 32'd6000);
    send_beat(16'd16000, 16'd0, 16'd0, 16'd0, 12'd100, 12'd1019, 32'd8000);
    send_beat(16'd16000, 16'd0, 16'd0, 16'd0, 12'd500, 12'd1020, 32'd9000);

    // bounds shift up, down, none, and negative half rounding
    set_config(12'd1000, 10'd20, 12'd1000, 10'd20, 12'd1000, 12'd2000, 1'b1, 16'd1000);
    send_beat(16'd8000, 16'd0, 16'd0, 16'd0, 12'd1500, 12'd1500, 32'd10000);
    send_beat(16'd40000, 16'd0, 16'd0, 16'd0, 12'd1500, 12'd1500, 32'd10001);
    send_beat(16'd24000, 16'd1600, 16'd0, 16'd0, 12'd1500, 12'd1500, 32'd10002);
    send_beat(16'd0, 16'd0, 16'd8, 16'd0, 12'd1500, 12'd1500, 32'd10003);
    send_beat(16'd0, 16'd0, 16'd7, 16'd0, 12'd1500, 12'd1500, 32'd10004);

    clock_ms = $urandom;
    set_config(12'd1000, 10'd20, 12'd1000, 10'd20, 12'd1000, 12'd2000, 1'b1, 16'd50);
    long_hold_req = 1'b1;
    run_phase(200);
    set_config(12'd4095, 10'd1023, 12'd4095, 10'd1023, 12'd0, 12'd4095, 1'b1, 16'd65535);
    run_phase(200);
    set_config(12'd0, 10'd0, 12'd0, 10'd0, 12'd4095, 12'd0, 1'b1, 16'd0);
    run_phase(150);
    set_config(12'd200, 10'd1023, 12'd150, 10'd0, 12'd1500, 12'd1200, 1'b0, 16'd3);
    run_phase(200);
    for (int k = 0; k < 2; k++) begin
      set_config(12'($urandom_range(100, 2000)), 10'($urandom_range(0, 1023)),
                 12'($urandom_range(100, 2000)), 10'($urandom_range(0, 1023)),
                 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                 1'($urandom_range(0, 1)), 16'($urandom_range(0, 300)));
      if (k == 1) idle_on = 1'b0;
      run_phase(k == 0 ? 250 : 200);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/qxm_pkg.sv
rtl/core/qxm_mix.sv
rtl/core/qxm_shape.sv
rtl/core/quad_x_motor_mixer_arming.sv
dv/qxm_mixer_checker.sv
dv/tb_top.sv
